// ----- rtl/swr_pkg.sv -----
package swr_pkg;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_NAK     = 2'd2;
  localparam logic [1:0] KIND_DROP    = 2'd3;

  // datagram layout
  localparam logic [14:0] HDR_BYTES  = 15'd6;
  localparam logic [14:0] POS_CSUM   = 15'd0;
  localparam logic [14:0] POS_FLAG   = 15'd1;
  localparam logic [14:0] POS_SEQ_HI = 15'd2;
  localparam logic [14:0] POS_SEQ_LO = 15'd3;
  localparam logic [14:0] POS_LEN_HI = 15'd4;
  localparam logic [14:0] POS_LEN_LO = 15'd5;
  localparam logic [14:0] POS_MAX    = 15'h7fff;
  localparam logic [7:0]  LAST_MARK  = 8'h41;
  localparam logic [7:0]  SUM_GOOD   = 8'hff;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_datagram;
  } swr_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [13:0] ack_seq;
    logic        final_packet;
    logic        run_end;
  } swr_out_t;

  // which result slots one byte fills
  typedef struct packed {
    logic payload;
    logic verdict;
  } swr_push_t;

endpackage

// ----- rtl/swr_frame.sv -----
module swr_frame
  import swr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  swr_in_t   item,
  output swr_push_t push,
  output swr_out_t  res_payload,
  output swr_out_t  res_verdict
);

  logic [13:0] exp_seq_r, exp_seq_nxt;
  logic [14:0] pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [13:0] cseq_r, cseq_nxt;
  logic [13:0] len_r, len_nxt;
  logic        flag_r, flag_nxt;

  logic        in_hdr;
  logic        in_body;
  logic [14:0] body_pos;
  logic [8:0]  sum_raw;
  logic [7:0]  sum_add;
  logic [6:0]  low7;
  logic        eod;
  logic        seq_match;
  logic        sum_ok;

  assign eod      = item.end_of_datagram;
  assign low7     = item.rx_byte[6:0];
  assign in_hdr   = (pos_r < HDR_BYTES);
  assign body_pos = pos_r - HDR_BYTES;
  assign in_body  = !in_hdr && (body_pos < {1'b0, len_r});

  // ones-complement add with end-around carry
  assign sum_raw = {1'b0, sum_r} + {1'b0, item.rx_byte};
  assign sum_add = sum_raw[7:0] + {7'd0, sum_raw[8]};

  // header capture and running sum
  always_comb begin
    sum_nxt  = sum_r;
    cseq_nxt = cseq_r;
    len_nxt  = len_r;
    flag_nxt = flag_r;
    if (in_hdr || in_body) begin
      sum_nxt = sum_add;
    end
    if (in_hdr) begin
      unique case (pos_r)
        POS_FLAG:   flag_nxt = (item.rx_byte == LAST_MARK);
        POS_SEQ_HI: cseq_nxt = {low7, 7'd0};
        POS_SEQ_LO: cseq_nxt = {cseq_r[13:7], low7};
        POS_LEN_HI: len_nxt  = {low7, 7'd0};
        POS_LEN_LO: len_nxt  = {len_r[13:7], low7};
        default:    ;
      endcase
    end
  end

  assign seq_match = (cseq_nxt == exp_seq_r);
  assign sum_ok    = (sum_nxt == SUM_GOOD);

  // results for this byte
  always_comb begin
    push.payload = in_body;
    push.verdict = eod;

    res_payload.kind         = KIND_PAYLOAD;
    res_payload.payload_byte = item.rx_byte;
    res_payload.ack_seq      = 14'd0;
    res_payload.final_packet = 1'b0;
    res_payload.run_end      = !eod;

    res_verdict.payload_byte = 8'd0;
    res_verdict.ack_seq      = 14'd0;
    res_verdict.final_packet = 1'b0;
    res_verdict.run_end      = 1'b1;
    if (!seq_match) begin
      res_verdict.kind = KIND_DROP;
    end else if (sum_ok) begin
      res_verdict.kind         = KIND_ACK;
      res_verdict.ack_seq      = cseq_nxt;
      res_verdict.final_packet = flag_nxt;
    end else begin
      res_verdict.kind = KIND_NAK;
    end
  end

  // position advance and expected sequence
  always_comb begin
    pos_nxt     = (pos_r < POS_MAX) ? pos_r + 15'd1 : pos_r;
    exp_seq_nxt = exp_seq_r;
    if (eod && seq_match && sum_ok) begin
      exp_seq_nxt = exp_seq_r + 14'd1;
    end
  end

  // state registers; the datagram state is cleared at end of datagram
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r <= '0;
      pos_r     <= '0;
      sum_r     <= '0;
      cseq_r    <= '0;
      len_r     <= '0;
      flag_r    <= 1'b0;
    end else if (step) begin
      exp_seq_r <= exp_seq_nxt;
      if (eod) begin
        pos_r  <= '0;
        sum_r  <= '0;
        cseq_r <= '0;
        len_r  <= '0;
        flag_r <= 1'b0;
      end else begin
        pos_r  <= pos_nxt;
        sum_r  <= sum_nxt;
        cseq_r <= cseq_nxt;
        len_r  <= len_nxt;
        flag_r <= flag_nxt;
      end
    end
  end

endmodule

// ----- rtl/swr_result_fifo.sv -----
module swr_result_fifo
  import swr_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  swr_push_t push,
  input  swr_out_t  res_payload,
  input  swr_out_t  res_verdict,
  output logic      room_for_two,
  output logic      out_valid,
  input  logic      out_ready,
  output swr_out_t  out_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] ROOM_LIMIT = CW'(DEPTH - 2);

  swr_out_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [PW-1:0]   wr_second;
  logic            pop;
  logic [1:0]      n_push;
  swr_out_t        first_res;

  assign room_for_two = (count_r <= ROOM_LIMIT);
  assign out_valid    = (count_r != '0);
  assign out_data     = mem_r[rd_ptr_r];
  assign pop          = out_valid && out_ready;

  // payload result goes ahead of the verdict
  assign first_res = push.payload ? res_payload : res_verdict;
  assign n_push    = {1'b0, push.payload} + {1'b0, push.verdict};
  assign wr_second = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    if (n_push == 2'd1) begin
      wr_ptr_nxt = wr_second;
    end else if (n_push == 2'd2) begin
      wr_ptr_nxt = (wr_second == PW'(DEPTH - 1)) ? '0 : wr_second + PW'(1);
    end
    rd_ptr_nxt = rd_ptr_r;
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    count_nxt = count_r + CW'(n_push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem_r[wr_ptr_r] <= first_res;
    end
    if (n_push == 2'd2) begin
      mem_r[wr_second] <= res_verdict;
    end
  end

endmodule

// ----- rtl/stop_and_wait_receiver_unit.sv -----
// an accepted byte is held in the input register, then its results are written
// to the result queue; one byte per cycle while the queue has room for two
// results; a byte carrying both a payload result and a verdict fills two entries of a four-entry queue
// reset: synchronous active-low rst_n clears the expected sequence, the
// datagram state, the input valid bit and the result queue
module stop_and_wait_receiver_unit
  import swr_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  swr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output swr_out_t out_data
);

  logic      in_valid_r;
  swr_in_t   in_data_r;
  logic      room_for_two;
  logic      step;
  swr_push_t push_raw;
  swr_push_t push;
  swr_out_t  res_payload;
  swr_out_t  res_verdict;

  // the registered byte is processed when the queue can take both results
  assign step     = in_valid_r && room_for_two;
  assign in_ready = !in_valid_r || step;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
  end

  swr_frame u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (in_data_r),
    .push        (push_raw),
    .res_payload (res_payload),
    .res_verdict (res_verdict)
  );

  // gate result pushes with the step
  assign push.payload = push_raw.payload && step;
  assign push.verdict = push_raw.verdict && step;

  swr_result_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_result_fifo (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .res_payload  (res_payload),
    .res_verdict  (res_verdict),
    .room_for_two (room_for_two),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import swr_pkg::*;

  localparam int          CYCLE_LIMIT  = 100000;
  localparam int          RANDOM_ITEMS = 500;
  localparam int          MAX_REPORTS  = 10;

  typedef logic [7:0] byte_q_t[$];
  typedef enum logic [1:0] {RDY_ALWAYS, RDY_MOSTLY, RDY_COIN, RDY_SPARSE} ready_mode_t;

  // mirror of the receiver state and the verdicts it owes
  class datagram_predictor;
    logic [13:0] exp_seq;
    logic [14:0] pos;
    logic [7:0]  sum;
    logic [13:0] cap_seq;
    logic [13:0] decl_len;
    logic        flag_last;
    swr_out_t    expected_results[$];
    int          errors;

    function new();
      exp_seq = '0;
      errors  = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos       = '0;
      sum       = '0;
      cap_seq   = '0;
      decl_len  = '0;
      flag_last = 1'b0;
    endfunction

    // 8-bit ones-complement add with end-around carry
    static function logic [7:0] ones_add(logic [7:0] a, logic [7:0] b);
      logic [8:0] t;
      t = a + b;
      return t[7:0] + t[8];
    endfunction

    // returns 1 when the byte is past the declared length and ends nothing
    function bit note_byte(swr_in_t item);
      logic [7:0] b;
      logic       eod;
      logic       payload;
      logic       in_header;
      swr_out_t   r;
      b         = item.rx_byte;
      eod       = item.end_of_datagram;
      payload   = 1'b0;
      in_header = pos < HDR_BYTES;
      if (in_header) begin
        sum = ones_add(sum, b);
        case (pos)
          POS_FLAG:   flag_last = (b == LAST_MARK);
          POS_SEQ_HI: cap_seq = {b[6:0], 7'd0};
          POS_SEQ_LO: cap_seq[6:0] = b[6:0];
          POS_LEN_HI: decl_len = {b[6:0], 7'd0};
          POS_LEN_LO: decl_len[6:0] = b[6:0];
          default: ;
        endcase
      end else if (pos - HDR_BYTES < {1'b0, decl_len}) begin
        sum     = ones_add(sum, b);
        payload = 1'b1;
      end
      if (pos != POS_MAX) pos = pos + 15'd1;

      // tentative payload byte first
      if (payload) begin
        r              = '0;
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        r.run_end      = !eod;
        expected_results.push_back(r);
      end

      // verdict on the closing byte
      if (eod) begin
        r         = '0;
        r.run_end = 1'b1;
        if (cap_seq == exp_seq) begin
          if (sum == SUM_GOOD) begin
            r.kind         = KIND_ACK;
            r.ack_seq      = cap_seq;
            r.final_packet = flag_last;
            exp_seq        = exp_seq + 14'd1;
          end else begin
            r.kind = KIND_NAK;
          end
        end else begin
          r.kind = KIND_DROP;
        end
        expected_results.push_back(r);
        clear_frame();
      end
      return !in_header && !payload && !eod;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("%s", msg);
    endfunction

    function void check_result(swr_out_t got);
      swr_out_t want;
      if (expected_results.size() == 0) begin
        report($sformatf("unexpected result kind=%0d byte=%02h seq=%0d fin=%0b end=%0b",
                         got.kind, got.payload_byte, got.ack_seq, got.final_packet,
                         got.run_end));
      end else begin
        want = expected_results.pop_front();
        if (got.kind !== want.kind || got.payload_byte !== want.payload_byte ||
            got.ack_seq !== want.ack_seq || got.final_packet !== want.final_packet ||
            got.run_end !== want.run_end) begin
          report($sformatf({"mismatch: expected kind=%0d byte=%02h seq=%0d fin=%0b end=%0b",
                            " got kind=%0d byte=%02h seq=%0d fin=%0b end=%0b"},
                           want.kind, want.payload_byte, want.ack_seq, want.final_packet,
                           want.run_end, got.kind, got.payload_byte, got.ack_seq,
                           got.final_packet, got.run_end));
        end
      end
    endfunction
  endclass

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  swr_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  swr_out_t out_data;

  datagram_predictor pred;
  bit          gaps_on     = 1'b1;
  int          burst_left  = 0;
  int          items_done  = 0;
  int          cycle_count = 0;
  ready_mode_t rdy_mode    = RDY_ALWAYS;
  int          mode_left   = 0;
  int          rdy_count   = 0;

  stop_and_wait_receiver_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) pred.check_result(out_data);
      if (mode_left == 0) begin
        rdy_mode  = ready_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(32, 400);
      end else begin
        mode_left--;
      end
      case (rdy_mode)
        RDY_ALWAYS: out_ready <= 1'b1;
        RDY_MOSTLY: out_ready <= (rdy_count % 4) != 0;
        RDY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        default:    out_ready <= (rdy_count % 7) < 2;
      endcase
      rdy_count++;
    end
  end

  function automatic byte_q_t rand_bytes(int n);
    byte_q_t q;
    for (int i = 0; i < n; i++) q.push_back(8'($urandom));
    return q;
  endfunction

  // header with a checksum over the header and the payload within len;
  // payload bytes past len go out as trailing junk
  function automatic byte_q_t build_datagram(logic [13:0] seq, bit last, logic [13:0] len,
                                             byte_q_t pay, bit corrupt);
    byte_q_t    q;
    logic [7:0] flag;
    logic [7:0] s;
    flag = 8'($urandom);
    if (last) flag = LAST_MARK;
    else if (flag == LAST_MARK) flag = 8'h00;
    q = {8'h00, flag, {1'($urandom), seq[13:7]}, {1'($urandom), seq[6:0]},
         {1'($urandom), len[13:7]}, {1'($urandom), len[6:0]}};
    s = '0;
    for (int i = 1; i < 6; i++) s = datagram_predictor::ones_add(s, q[i]);
    for (int i = 0; i < pay.size() && i < int'(len); i++)
      s = datagram_predictor::ones_add(s, pay[i]);
    q[0] = ~s;
    if (corrupt) q[0] = q[0] ^ 8'($urandom_range(1, 255));
    foreach (pay[i]) q.push_back(pay[i]);
    return q;
  endfunction

  // one byte transfer, with burst gaps on the sender side
  task automatic send_rx_byte(input logic [7:0] b, input logic eod);
    swr_in_t item;
    item.rx_byte         = b;
    item.end_of_datagram = eod;
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (!pred.note_byte(item)) items_done++;
  endtask

  task automatic send_datagram(input byte_q_t frame);
    foreach (frame[i]) send_rx_byte(frame[i], i == frame.size() - 1);
  endtask

  initial begin
    byte_q_t     pay;
    byte_q_t     none;
    byte_q_t     frame;
    int          pick;
    logic [13:0] seq;
    logic [13:0] len;
    pred = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone zero byte closing a datagram: matching sequence, bad sum
    frame = {8'h00};
    send_datagram(frame);
    // good last packet with extreme payload bytes
    pay = {8'h00, 8'hff};
    send_datagram(build_datagram(14'd0, 1'b1, 14'd2, pay, 1'b0));
    // duplicate of the accepted packet
    send_datagram(build_datagram(14'd0, 1'b0, 14'd0, none, 1'b0));
    // bad checksum
    pay = {8'h5a};
    send_datagram(build_datagram(14'd1, 1'b0, 14'd1, pay, 1'b1));
    // bytes past the declared length
    pay = {8'ha5, 8'h3c, 8'hc3};
    send_datagram(build_datagram(14'd1, 1'b0, 14'd1, pay, 1'b0));
    // header cut short after the sequence bytes
    frame = build_datagram(14'd2, 1'b0, 14'd3, none, 1'b0);
    while (frame.size() > 4) void'(frame.pop_back());
    send_datagram(frame);

    // good packets back to back, then a stale one
    send_datagram(build_datagram(pred.exp_seq, 1'b0, 14'd0, none, 1'b0));
    send_datagram(build_datagram(pred.exp_seq, 1'b1, 14'd1, rand_bytes(1), 1'b0));
    send_datagram(build_datagram(pred.exp_seq, 1'b0, 14'd0, none, 1'b0));
    send_datagram(build_datagram(pred.exp_seq - 14'd1, 1'b0, 14'd0, none, 1'b0));

    // random datagrams: mostly well formed, some corrupted, stale, cut or noise
    items_done = 0;
    while (items_done < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      seq  = pred.exp_seq;
      if (pick >= 72 && pick < 82) begin
        if ($urandom_range(0, 1) != 0) seq = seq - 14'd1;
        else seq = 14'($urandom);
      end
      if (pick >= 92) begin
        frame = rand_bytes($urandom_range(1, 12));
      end else begin
        pay = rand_bytes($urandom_range(0, 12));
        len = 14'(pay.size());
        if (pick < 60 && $urandom_range(0, 3) == 0)
          pay = {pay, rand_bytes($urandom_range(1, 3))};
        frame = build_datagram(seq, $urandom_range(0, 3) == 0, len, pay,
                               pick >= 60 && pick < 72);
        if (pick >= 82) begin
          pick = $urandom_range(1, frame.size());
          while (frame.size() > pick) void'(frame.pop_back());
        end
      end
      send_datagram(frame);
    end
    in_valid <= 1'b0;

    // drain
    while (pred.expected_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (pred.errors == 0 && pred.expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- stop_and_wait_receiver_unit.f -----
rtl/swr_pkg.sv
rtl/swr_frame.sv
rtl/swr_result_fifo.sv
rtl/stop_and_wait_receiver_unit.sv
sim/tb_top.sv
